>>> sv/upper_envelope_line_store_top_macros.svh
// ----------------------------------------------------------------------------
// upper envelope line store assertion macros
// shared property shorthands for the controller and the datapath
// ----------------------------------------------------------------------------
`ifndef UPPER_ENVELOPE_LINE_STORE_TOP_MACROS_SVH
`define UPPER_ENVELOPE_LINE_STORE_TOP_MACROS_SVH

// same-cycle implication on clk_i, off while rst_ni is low
`define UELS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk_i, off while rst_ni is low
`define UELS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/uels_pkg.sv
// ----------------------------------------------------------------------------
// uels_pkg
// types, widths and codes shared by the upper envelope line store
// ----------------------------------------------------------------------------
`default_nettype none

package uels_pkg;

  // field widths
  localparam int LINE_K_W    = 32;
  localparam int LINE_B_W    = 61;
  localparam int X_W         = 31;
  localparam int VAL_W       = 63;
  localparam int STAT_W      = 3;
  localparam int ISECT_W     = 62;
  localparam int DEN_W       = 33;
  localparam int DEF_MAX_LINES = 256;

  // stream packing
  localparam int IN_K_LSB    = 0;
  localparam int IN_B_LSB    = IN_K_LSB + LINE_K_W;
  localparam int IN_X_LSB    = IN_B_LSB + LINE_B_W;
  localparam int IN_FIELDS_W = IN_X_LSB + X_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int IN_USER_W   = 1;
  localparam int OUT_DATA_W  = ((VAL_W + 7) / 8) * 8;
  localparam int OUT_USER_W  = STAT_W;

  typedef struct packed {
    logic signed [LINE_K_W-1:0] k;
    logic signed [LINE_B_W-1:0] b;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  typedef enum logic [STAT_W-1:0] {
    ST_QUERY_OK = 3'd0,
    ST_KEPT     = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_EMPTY    = 3'd4
  } stat_e;

  typedef enum logic [2:0] {
    RA_POS, RA_POS_M1, RA_R0, RA_I, RA_I_M1, RA_I_P1, RA_SRC
  } raddr_e;

  typedef enum logic [1:0] {
    LS_HOLD, LS_RAM, LS_NEW, LS_NEXT
  } lsrc_e;

  typedef enum logic [1:0] {
    PR_AM, PR_MC, PR_AC
  } pair_e;

  typedef enum logic [1:0] {
    CX_PRE, CX_LEFT, CX_RIGHT
  } ctx_e;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_SCAN, S_SCAN_CHK, S_PRE, S_PRE_A, S_PRE_C,
    S_L_INIT, S_L_CHK, S_L_A, S_L_M, S_R_INIT, S_RT_CHK, S_RT_M, S_RT_C,
    S_RED1, S_RED1W, S_RED2, S_RED2W, S_TOT, S_MV_RD, S_MV_WR, S_MV_END,
    S_Q_RA, S_Q_LA, S_Q_CHK, S_Q_LC, S_Q_DIV, S_Q_WAIT, S_Q_MUL, S_Q_ADD,
    S_FIN
  } state_e;

  typedef struct packed {
    logic   take;
    logic   pos_clr;
    logic   pos_inc;
    logic   eq_clr;
    logic   eq_ld;
    raddr_e raddr;
    lsrc_e  ld_a;
    lsrc_e  ld_m;
    lsrc_e  ld_c;
    logic   div_start;
    pair_e  pair;
    logic   save_t1;
    logic   i_ld_pos_m1;
    logic   i_ld_r0;
    logic   i_clr;
    logic   i_dec;
    logic   i_inc;
    logic   lk_set;
    logic   lk_zero;
    logic   mv_del;
    logic   mv_ins;
    logic   mv_step;
    logic   wr_mv;
    logic   wr_new;
    logic   n_total;
    logic   n_dec;
    logic   val_ld;
    logic   out_load;
    stat_e  out_status;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic n_zero;
    logic pos_lt_n;
    logic pos_ge1;
    logic r0_lt_n;
    logic eq;
    logic i_ge1;
    logic i_p1_lt_n;
    logic slope_lt;
    logic slope_eq;
    logic icpt_ge;
    logic div_done;
    logic red;
    logic x_lt;
    logic total_gt_max;
    logic mv_cnt_zero;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

>>> sv/uels_ram.sv
// ----------------------------------------------------------------------------
// uels_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module uels_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> sv/uels_isect.sv
// ----------------------------------------------------------------------------
// uels_isect
// ceiling intersection abscissa of two lines, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module uels_isect
  import uels_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire line_t                      lo_i,
  input  wire line_t                      hi_i,
  output logic                            done_o,
  output logic signed [ISECT_W-1:0]       res_o
);

  localparam int STEPS = LINE_B_W;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic                    busy_q, fin_q, done_q;
  logic [CNT_W-1:0]        cnt_q;
  logic [LINE_B_W-1:0]     dvd_q;
  logic [LINE_K_W-1:0]     den_q, rem_q;
  logic                    neg_q, bad_q;
  logic signed [ISECT_W-1:0] res_q;

  logic signed [ISECT_W-1:0] num;
  logic signed [DEN_W-1:0]   den;
  logic [ISECT_W-1:0]        mag;
  logic [LINE_K_W:0]         rem_sh, rem_sub;
  logic                      qbit;
  logic [ISECT_W-1:0]        quo;

  // operands: b_lo - b_hi over k_hi - k_lo
  assign num = {lo_i.b[LINE_B_W-1], lo_i.b} - {hi_i.b[LINE_B_W-1], hi_i.b};
  assign den = {hi_i.k[LINE_K_W-1], hi_i.k} - {lo_i.k[LINE_K_W-1], lo_i.k};
  assign mag = num[ISECT_W-1] ? ISECT_W'(-num) : ISECT_W'(num);

  // restoring step
  assign rem_sh  = {rem_q, dvd_q[LINE_B_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign qbit    = (rem_sh >= {1'b0, den_q});
  assign quo     = {{(ISECT_W-LINE_B_W){1'b0}}, dvd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= mag[LINE_B_W-1:0];
      rem_q <= '0;
      den_q <= den[LINE_K_W-1:0];
      neg_q <= num[ISECT_W-1];
      bad_q <= den[DEN_W-1] | (den == '0);
    end else if (busy_q) begin
      dvd_q <= {dvd_q[LINE_B_W-2:0], qbit};
      rem_q <= qbit ? rem_sub[LINE_K_W-1:0] : rem_sh[LINE_K_W-1:0];
    end
    // ceiling rounding: up for positive, truncation is already ceiling below zero
    if (fin_q) begin
      if (bad_q) begin
        res_q <= '0;
      end else if (neg_q) begin
        res_q <= -$signed(quo);
      end else begin
        res_q <= $signed(quo + ISECT_W'(rem_q != '0));
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

`default_nettype wire

>>> sv/uels_dp.sv
// ----------------------------------------------------------------------------
// uels_dp
// datapath: line store, index registers, intersection unit and output stage
// ----------------------------------------------------------------------------
`default_nettype none

`include "upper_envelope_line_store_top_macros.svh"

module uels_dp
  import uels_pkg::*;
#(
  parameter int MAX_LINES = DEF_MAX_LINES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  input  wire logic [IN_DATA_W-1:0]  in_data_i,
  input  wire logic [IN_USER_W-1:0]  in_user_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0]      out_data_o,
  output logic [OUT_USER_W-1:0]      out_user_o
);

  localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CW = $clog2(MAX_LINES + 1);

  // item registers
  logic                    kind_q;
  line_t                   new_q;
  logic signed [X_W-1:0]   x_q;

  // index registers
  logic [CW-1:0] n_q, pos_q, i_q, lk_q, src_q, dst_q, cnt_q;
  logic          dir_q, eq_q;

  // line operand registers
  line_t a_q, m_q, c_q, rd;

  logic signed [ISECT_W-1:0] t1_q, div_res;
  logic                      div_done;
  line_t                     lo, hi;

  logic signed [VAL_W-1:0]   prod_q;
  logic [VAL_W-1:0]          val_q;
  logic signed [VAL_W:0]     sum;

  logic                      ov_q;
  stat_e                     os_q;
  logic [VAL_W-1:0]          oval_q;

  logic [CW-1:0]   r0, raddr_w, waddr_w;
  logic [CW:0]     i_p1, total;
  logic            we;
  line_t           wdata;

  assign r0    = pos_q + CW'(eq_q);
  assign i_p1  = {1'b0, i_q} + 1'b1;
  assign total = {1'b0, lk_q} + 1'b1 + {1'b0, n_q} - {1'b0, i_q};

  // read address select
  always_comb begin
    case (cmd_i.raddr)
      RA_POS:    raddr_w = pos_q;
      RA_POS_M1: raddr_w = pos_q - 1'b1;
      RA_R0:     raddr_w = r0;
      RA_I:      raddr_w = i_q;
      RA_I_M1:   raddr_w = i_q - 1'b1;
      RA_I_P1:   raddr_w = i_p1[CW-1:0];
      RA_SRC:    raddr_w = src_q;
      default:   raddr_w = pos_q;
    endcase
  end

  // write port: moved entry or new line
  assign we      = cmd_i.wr_mv | cmd_i.wr_new;
  assign waddr_w = cmd_i.wr_new ? lk_q : dst_q;
  assign wdata   = cmd_i.wr_new ? new_q : rd;

  uels_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_LINES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr_w[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr_w[AW-1:0]),
    .rdata_o (rd)
  );

  // intersection operand pair
  always_comb begin
    case (cmd_i.pair)
      PR_AM:   begin lo = a_q; hi = m_q; end
      PR_MC:   begin lo = m_q; hi = c_q; end
      PR_AC:   begin lo = a_q; hi = c_q; end
      default: begin lo = a_q; hi = m_q; end
    endcase
  end

  uels_isect u_isect (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .lo_i    (lo),
    .hi_i    (hi),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  // control registers: count, indices, move counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q   <= '0;
      pos_q <= '0;
      i_q   <= '0;
      lk_q  <= '0;
      src_q <= '0;
      dst_q <= '0;
      cnt_q <= '0;
      dir_q <= 1'b0;
      eq_q  <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      if (cmd_i.pos_clr) pos_q <= '0;
      if (cmd_i.pos_inc) pos_q <= pos_q + 1'b1;
      if (cmd_i.eq_clr)  eq_q  <= 1'b0;
      if (cmd_i.eq_ld)   eq_q  <= (rd.k == new_q.k);
      if (cmd_i.i_ld_pos_m1) i_q <= pos_q - 1'b1;
      if (cmd_i.i_ld_r0)     i_q <= r0;
      if (cmd_i.i_clr)       i_q <= '0;
      if (cmd_i.i_dec)       i_q <= i_q - 1'b1;
      if (cmd_i.i_inc)       i_q <= i_p1[CW-1:0];
      if (cmd_i.lk_set)  lk_q <= i_p1[CW-1:0];
      if (cmd_i.lk_zero) lk_q <= '0;
      // close the gap left by a replaced line
      if (cmd_i.mv_del) begin
        src_q <= pos_q + 1'b1;
        dst_q <= pos_q;
        cnt_q <= n_q - pos_q - 1'b1;
        dir_q <= 1'b0;
      end
      // move the right tail next to the kept left part
      if (cmd_i.mv_ins) begin
        cnt_q <= n_q - i_q;
        if (lk_q == i_q) begin
          src_q <= n_q - 1'b1;
          dst_q <= n_q;
          dir_q <= 1'b1;
        end else begin
          src_q <= i_q;
          dst_q <= lk_q + 1'b1;
          dir_q <= 1'b0;
        end
      end
      if (cmd_i.mv_step) begin
        cnt_q <= cnt_q - 1'b1;
        src_q <= dir_q ? src_q - 1'b1 : src_q + 1'b1;
        dst_q <= dir_q ? dst_q - 1'b1 : dst_q + 1'b1;
      end
      if (cmd_i.n_total) n_q <= total[CW-1:0];
      if (cmd_i.n_dec)   n_q <= n_q - 1'b1;
      // output valid
      if (cmd_i.out_load) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      kind_q  <= in_user_i[0];
      new_q.k <= in_data_i[IN_K_LSB +: LINE_K_W];
      new_q.b <= in_data_i[IN_B_LSB +: LINE_B_W];
      x_q     <= in_data_i[IN_X_LSB +: X_W];
    end
    case (cmd_i.ld_a)
      LS_RAM:  a_q <= rd;
      LS_NEW:  a_q <= new_q;
      LS_NEXT: a_q <= c_q;
      default: a_q <= a_q;
    endcase
    case (cmd_i.ld_m)
      LS_RAM:  m_q <= rd;
      LS_NEW:  m_q <= new_q;
      default: m_q <= m_q;
    endcase
    case (cmd_i.ld_c)
      LS_RAM:  c_q <= rd;
      LS_NEW:  c_q <= new_q;
      default: c_q <= c_q;
    endcase
    if (cmd_i.save_t1) t1_q <= div_res;
    // line value at the query point
    prod_q <= $signed(a_q.k) * $signed(x_q);
    if (cmd_i.val_ld) val_q <= sum[VAL_W-1:0];
    if (cmd_i.out_load) begin
      os_q   <= cmd_i.out_status;
      oval_q <= (cmd_i.out_status == ST_QUERY_OK) ? val_q : '0;
    end
  end

  assign sum = {prod_q[VAL_W-1], prod_q} +
               {{(VAL_W+1-LINE_B_W){a_q.b[LINE_B_W-1]}}, a_q.b};

  // status to the controller
  always_comb begin
    sts_o              = '0;
    sts_o.kind         = kind_q;
    sts_o.n_zero       = (n_q == '0);
    sts_o.pos_lt_n     = (pos_q < n_q);
    sts_o.pos_ge1      = (pos_q != '0);
    sts_o.r0_lt_n      = (r0 < n_q);
    sts_o.eq           = eq_q;
    sts_o.i_ge1        = (i_q != '0);
    sts_o.i_p1_lt_n    = (i_p1 < {1'b0, n_q});
    sts_o.slope_lt     = ($signed(rd.k) < $signed(new_q.k));
    sts_o.slope_eq     = (rd.k == new_q.k);
    sts_o.icpt_ge      = ($signed(rd.b) >= $signed(new_q.b));
    sts_o.div_done     = div_done;
    sts_o.red          = (t1_q >= div_res);
    sts_o.x_lt         = ($signed({{(ISECT_W-X_W){x_q[X_W-1]}}, x_q}) < div_res);
    sts_o.total_gt_max = (total > (CW+1)'(MAX_LINES));
    sts_o.mv_cnt_zero  = (cnt_q == '0);
    sts_o.out_busy     = ov_q & ~out_ready_i;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = {{(OUT_DATA_W-VAL_W){1'b0}}, oval_q};
  assign out_user_o  = os_q;

  `UELS_ASSERT_IMP(a_count_bound, 1'b1, (n_q <= CW'(MAX_LINES)), "line count beyond store depth")
  `UELS_ASSERT_IMP(a_insert_fits, cmd_i.wr_new, (!sts_o.total_gt_max), "insert overflows store")
  `UELS_ASSERT_NXT(a_div_not_instant, cmd_i.div_start, (!div_done), "intersection done too early")

endmodule

`default_nettype wire

>>> sv/uels_ctrl.sv
// ----------------------------------------------------------------------------
// uels_ctrl
// controller: sequences search, redundancy tests, pruning moves and queries
// ----------------------------------------------------------------------------
`default_nettype none

`include "upper_envelope_line_store_top_macros.svh"

module uels_ctrl
  import uels_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  ctx_e   ctx_q, ctx_d;
  logic   ins_q, ins_d;
  stat_e  stat_q, stat_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ctx_q   <= CX_PRE;
      ins_q   <= 1'b0;
      stat_q  <= ST_QUERY_OK;
    end else begin
      state_q <= state_d;
      ctx_q   <= ctx_d;
      ins_q   <= ins_d;
      stat_q  <= stat_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctx_d   = ctx_q;
    ins_d   = ins_q;
    stat_d  = stat_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_DISP: begin
        if (sts_i.kind) begin
          if (sts_i.n_zero) begin
            stat_d  = ST_EMPTY;
            state_d = S_FIN;
          end else begin
            cmd_o.i_clr = 1'b1;
            state_d     = S_Q_RA;
          end
        end else begin
          cmd_o.pos_clr = 1'b1;
          state_d       = S_SCAN;
        end
      end
      // find the first slope not below the new one
      S_SCAN: begin
        if (sts_i.pos_lt_n) begin
          cmd_o.raddr = RA_POS;
          state_d     = S_SCAN_CHK;
        end else begin
          cmd_o.eq_clr = 1'b1;
          state_d      = S_PRE;
        end
      end
      S_SCAN_CHK: begin
        if (sts_i.slope_lt) begin
          cmd_o.pos_inc = 1'b1;
          state_d       = S_SCAN;
        end else if (sts_i.slope_eq && sts_i.icpt_ge) begin
          stat_d  = ST_DROPPED;
          state_d = S_FIN;
        end else begin
          cmd_o.eq_ld = 1'b1;
          state_d     = S_PRE;
        end
      end
      // is the new line hidden by its neighbors
      S_PRE: begin
        if (sts_i.pos_ge1 && sts_i.r0_lt_n) begin
          cmd_o.raddr = RA_POS_M1;
          state_d     = S_PRE_A;
        end else begin
          state_d = S_L_INIT;
        end
      end
      S_PRE_A: begin
        cmd_o.ld_a  = LS_RAM;
        cmd_o.ld_m  = LS_NEW;
        cmd_o.raddr = RA_R0;
        state_d     = S_PRE_C;
      end
      S_PRE_C: begin
        cmd_o.ld_c = LS_RAM;
        ctx_d      = CX_PRE;
        state_d    = S_RED1;
      end
      // redundancy test of the middle line
      S_RED1: begin
        cmd_o.div_start = 1'b1;
        cmd_o.pair      = PR_AM;
        state_d         = S_RED1W;
      end
      S_RED1W: begin
        cmd_o.pair = PR_AM;
        if (sts_i.div_done) begin
          cmd_o.save_t1 = 1'b1;
          state_d       = S_RED2;
        end
      end
      S_RED2: begin
        cmd_o.div_start = 1'b1;
        cmd_o.pair      = PR_MC;
        state_d         = S_RED2W;
      end
      S_RED2W: begin
        cmd_o.pair = PR_MC;
        if (sts_i.div_done) begin
          case (ctx_q)
            CX_PRE: begin
              if (sts_i.red) begin
                if (sts_i.eq) begin
                  cmd_o.mv_del = 1'b1;
                  cmd_o.n_dec  = 1'b1;
                  ins_d        = 1'b0;
                  state_d      = S_MV_RD;
                end else begin
                  stat_d  = ST_DROPPED;
                  state_d = S_FIN;
                end
              end else begin
                state_d = S_L_INIT;
              end
            end
            CX_LEFT: begin
              if (sts_i.red) begin
                cmd_o.i_dec = 1'b1;
                state_d     = S_L_CHK;
              end else begin
                cmd_o.lk_set = 1'b1;
                state_d      = S_R_INIT;
              end
            end
            CX_RIGHT: begin
              if (sts_i.red) begin
                cmd_o.i_inc = 1'b1;
                state_d     = S_RT_CHK;
              end else begin
                state_d = S_TOT;
              end
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      // prune on the left, nearest first
      S_L_INIT: begin
        if (sts_i.pos_ge1) begin
          cmd_o.i_ld_pos_m1 = 1'b1;
          state_d           = S_L_CHK;
        end else begin
          cmd_o.lk_zero = 1'b1;
          state_d       = S_R_INIT;
        end
      end
      S_L_CHK: begin
        if (sts_i.i_ge1) begin
          cmd_o.raddr = RA_I_M1;
          state_d     = S_L_A;
        end else begin
          cmd_o.lk_set = 1'b1;
          state_d      = S_R_INIT;
        end
      end
      S_L_A: begin
        cmd_o.ld_a  = LS_RAM;
        cmd_o.raddr = RA_I;
        state_d     = S_L_M;
      end
      S_L_M: begin
        cmd_o.ld_m = LS_RAM;
        cmd_o.ld_c = LS_NEW;
        ctx_d      = CX_LEFT;
        state_d    = S_RED1;
      end
      // prune on the right
      S_R_INIT: begin
        cmd_o.i_ld_r0 = 1'b1;
        state_d       = S_RT_CHK;
      end
      S_RT_CHK: begin
        if (sts_i.i_p1_lt_n) begin
          cmd_o.raddr = RA_I;
          state_d     = S_RT_M;
        end else begin
          state_d = S_TOT;
        end
      end
      S_RT_M: begin
        cmd_o.ld_m  = LS_RAM;
        cmd_o.ld_a  = LS_NEW;
        cmd_o.raddr = RA_I_P1;
        state_d     = S_RT_C;
      end
      S_RT_C: begin
        cmd_o.ld_c = LS_RAM;
        ctx_d      = CX_RIGHT;
        state_d    = S_RED1;
      end
      S_TOT: begin
        if (sts_i.total_gt_max) begin
          stat_d  = ST_FULL;
          state_d = S_FIN;
        end else begin
          cmd_o.mv_ins = 1'b1;
          ins_d        = 1'b1;
          state_d      = S_MV_RD;
        end
      end
      // entry move, one read and one write per entry
      S_MV_RD: begin
        if (sts_i.mv_cnt_zero) begin
          state_d = S_MV_END;
        end else begin
          cmd_o.raddr = RA_SRC;
          state_d     = S_MV_WR;
        end
      end
      S_MV_WR: begin
        cmd_o.wr_mv   = 1'b1;
        cmd_o.mv_step = 1'b1;
        state_d       = S_MV_RD;
      end
      S_MV_END: begin
        if (ins_q) begin
          cmd_o.wr_new  = 1'b1;
          cmd_o.n_total = 1'b1;
          stat_d        = ST_KEPT;
        end else begin
          stat_d = ST_DROPPED;
        end
        state_d = S_FIN;
      end
      // query: walk the envelope until x lies left of the next crossing
      S_Q_RA: begin
        cmd_o.raddr = RA_I;
        state_d     = S_Q_LA;
      end
      S_Q_LA: begin
        cmd_o.ld_a = LS_RAM;
        state_d    = S_Q_CHK;
      end
      S_Q_CHK: begin
        if (sts_i.i_p1_lt_n) begin
          cmd_o.raddr = RA_I_P1;
          state_d     = S_Q_LC;
        end else begin
          state_d = S_Q_MUL;
        end
      end
      S_Q_LC: begin
        cmd_o.ld_c = LS_RAM;
        state_d    = S_Q_DIV;
      end
      S_Q_DIV: begin
        cmd_o.div_start = 1'b1;
        cmd_o.pair      = PR_AC;
        state_d         = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        cmd_o.pair = PR_AC;
        if (sts_i.div_done) begin
          if (sts_i.x_lt) begin
            state_d = S_Q_MUL;
          end else begin
            cmd_o.ld_a  = LS_NEXT;
            cmd_o.i_inc = 1'b1;
            state_d     = S_Q_CHK;
          end
        end
      end
      S_Q_MUL: begin
        state_d = S_Q_ADD;
      end
      S_Q_ADD: begin
        cmd_o.val_ld = 1'b1;
        stat_d       = ST_QUERY_OK;
        state_d      = S_FIN;
      end
      // hand the result to the output register
      S_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_status = stat_q;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `UELS_ASSERT_IMP(a_out_free, cmd_o.out_load, (!sts_i.out_busy), "result overwrites pending item")
  `UELS_ASSERT_IMP(a_done_waited, sts_i.div_done, (state_q == S_RED1W || state_q == S_RED2W || state_q == S_Q_WAIT), "intersection done outside a wait state")

endmodule

`default_nettype wire

>>> sv/upper_envelope_line_store_top.sv
// a query computes one intersection per line walked
// an add scans for its slope, runs redundancy tests (two serial divisions each) and moves entries
// one item in flight, results wait in an output register
// the intersection unit divides by shift and subtract; the store has one registered read port
// reset: asynchronous, active low; clears the line count and control, store contents undefined
// ----------------------------------------------------------------------------
// upper_envelope_line_store_top
// upper envelope of lines with max queries, stream in and stream out
// ----------------------------------------------------------------------------
`default_nettype none

module upper_envelope_line_store_top
  import uels_pkg::*;
#(
  parameter int MAX_LINES = DEF_MAX_LINES
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // slope [31:0], intercept [92:32], abscissa [123:93], zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind [0]
  input  wire logic [IN_USER_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // max_value [62:0], zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  // status [2:0]
  output logic [OUT_USER_W-1:0]      m_axis_tuser
);

  cmd_t cmd;
  sts_t sts;

  uels_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  uels_dp #(
    .MAX_LINES (MAX_LINES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire
